FILE: hdl/fcn_pkg.sv
// shared types and constants for the fragment chaining block
`default_nettype none
package fcn_pkg;

    localparam int CoordW = 32;
    localparam int ScoreW = 12;
    localparam int IdxW   = 6;
    localparam int ValW   = 32;

    typedef struct packed {
        logic [CoordW-1:0] first_start;
        logic [CoordW-1:0] first_end;
        logic [CoordW-1:0] second_start;
        logic [CoordW-1:0] second_end;
        logic [ScoreW-1:0] frag_score;
        logic              final_item;
    } frag_in_t;

    typedef struct packed {
        logic [IdxW-1:0]   fragment_index;
        logic [CoordW-1:0] out_first_start;
        logic [CoordW-1:0] out_first_end;
        logic [CoordW-1:0] out_second_start;
        logic [CoordW-1:0] out_second_end;
        logic [ScoreW-1:0] out_score;
        logic              chain_last;
    } frag_out_t;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_INIT_ORD,
        ST_SORT_I,
        ST_SORT_RD,
        ST_SORT_WAIT,
        ST_SORT_CMP,
        ST_SORT_PUT,
        ST_CH_I,
        ST_CH_RDI,
        ST_CH_SQ,
        ST_CH_J,
        ST_CH_RDJ,
        ST_CH_CMP,
        ST_CH_END,
        ST_TR_RD,
        ST_TR_STEP,
        ST_EM_RD,
        ST_EM_WAIT,
        ST_EM_FRAG,
        ST_EM_OUT
    } fcn_state_t;

    // command from controller to datapath
    typedef struct packed {
        fcn_state_t state;
        logic       enter;
        logic       take;
    } fcn_cmd_t;

    // status back to controller
    typedef struct packed {
        logic sort_move;
        logic ch_i_done;
        logic ch_j_done;
        logic sort_k_zero;
        logic sort_i_done;
        logic init_done;
        logic tr_done;
        logic em_done;
        logic have_frags;
    } fcn_stat_t;

endpackage
`default_nettype wire

FILE: hdl/fcn_ctrl.sv
// controller state machine for the fragment chaining block
`default_nettype none
module fcn_ctrl
    import fcn_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_fire,
    input  wire logic      in_final,
    input  wire logic      out_fire,
    input  wire fcn_stat_t stat,
    output fcn_cmd_t       cmd,
    output logic           in_ready,
    output logic           out_valid
);

    fcn_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_LOAD;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_fire && in_final)
                    state_next = ST_INIT_ORD;
            end
            ST_INIT_ORD:
            begin
                if (!stat.have_frags)
                    state_next = ST_LOAD;
                else if (stat.init_done)
                    state_next = ST_SORT_I;
            end
            ST_SORT_I:    state_next = stat.sort_i_done ? ST_CH_I : ST_SORT_RD;
            ST_SORT_RD:   state_next = stat.sort_k_zero ? ST_SORT_PUT : ST_SORT_WAIT;
            ST_SORT_WAIT: state_next = ST_SORT_CMP;
            ST_SORT_CMP:  state_next = stat.sort_move ? ST_SORT_RD : ST_SORT_PUT;
            ST_SORT_PUT:  state_next = ST_SORT_I;
            ST_CH_I:      state_next = stat.ch_i_done ? ST_TR_RD : ST_CH_RDI;
            ST_CH_RDI:    state_next = ST_CH_SQ;
            ST_CH_SQ:     state_next = ST_CH_J;
            ST_CH_J:      state_next = stat.ch_j_done ? ST_CH_END : ST_CH_RDJ;
            ST_CH_RDJ:    state_next = ST_CH_CMP;
            ST_CH_CMP:    state_next = ST_CH_J;
            ST_CH_END:    state_next = ST_CH_I;
            ST_TR_RD:     state_next = ST_TR_STEP;
            ST_TR_STEP:   state_next = stat.tr_done ? ST_EM_RD : ST_TR_RD;
            ST_EM_RD:     state_next = ST_EM_WAIT;
            ST_EM_WAIT:   state_next = ST_EM_FRAG;
            ST_EM_FRAG:   state_next = ST_EM_OUT;
            ST_EM_OUT:
            begin
                out_valid = 1'b1;
                if (out_fire)
                    state_next = stat.em_done ? ST_LOAD : ST_EM_RD;
            end
            default:      state_next = ST_LOAD;
        endcase
    end

    assign cmd.state = state_reg;
    assign cmd.enter = in_fire;
    assign cmd.take  = out_fire;

endmodule
`default_nettype wire

FILE: hdl/fcn_dp.sv
// datapath: fragment memories, insertion sort, chaining pass, traceback
`default_nettype none
module fcn_dp
    import fcn_pkg::*;
#(
    parameter int MaxFrag = 64
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire fcn_cmd_t cmd,
    input  wire frag_in_t in_word,
    output fcn_stat_t     stat,
    output frag_out_t     out_word
);

    localparam int AW = (MaxFrag > 1) ? $clog2(MaxFrag) : 1;
    localparam int CW = $clog2(MaxFrag + 1);

    // fragment memories, arrival order
    logic [CoordW-1:0] fs_mem [MaxFrag];
    logic [CoordW-1:0] fe_mem [MaxFrag];
    logic [CoordW-1:0] ss_mem [MaxFrag];
    logic [CoordW-1:0] se_mem [MaxFrag];
    logic [ScoreW-1:0] sc_mem [MaxFrag];
    // sorted order, chain values, predecessors, path
    logic [AW-1:0]     ord_mem [MaxFrag];
    logic [ValW-1:0]   cv_mem [MaxFrag];
    logic [AW:0]       pr_mem [MaxFrag];
    logic [AW-1:0]     path_mem [MaxFrag];

    logic [CW-1:0] count_reg;
    logic [CW-1:0] i_reg;
    logic [CW-1:0] k_reg;
    logic [AW-1:0] cur_reg;
    logic [CoordW-1:0] cur_fs_reg;
    logic [CoordW-1:0] fi_fs_reg, fi_ss_reg;
    logic [ValW-1:0] w_reg, cv_reg;
    logic [AW:0]   pred_reg;
    logic [AW-1:0] best_end_reg;
    logic [ValW-1:0] best_val_reg;
    logic [AW-1:0] pos_reg;
    logic [CW-1:0] len_reg;
    logic [CW-1:0] emk_reg;

    // registered memory read ports
    logic [AW-1:0]     ord_rd_reg;
    logic [AW:0]       pr_rd_reg;
    logic [ValW-1:0]   cv_rd_reg;
    logic [CoordW-1:0] fs_rd_reg, fe_rd_reg, ss_rd_reg, se_rd_reg;
    logic [ScoreW-1:0] sc_rd_reg;
    logic [AW-1:0]     path_rd_reg;

    logic [AW-1:0] ord_addr;
    logic [AW-1:0] frag_addr;
    logic [AW-1:0] k_m1;
    logic [AW-1:0] i_a, k_a;
    logic          cand_ok;
    logic [ValW-1:0] cand;
    logic [2*ScoreW-1:0] sq;

    assign i_a  = i_reg[AW-1:0];
    assign k_a  = k_reg[AW-1:0];
    assign k_m1 = AW'(k_reg - 1'b1);

    always_comb
    begin
        ord_addr  = k_m1;
        frag_addr = ord_rd_reg;
        case (cmd.state)
            ST_SORT_I:  ord_addr = i_a;
            ST_CH_I:    ord_addr = i_a;
            ST_CH_J:    ord_addr = k_a;
            ST_EM_RD:   ord_addr = path_rd_reg;
            ST_EM_WAIT: ord_addr = path_rd_reg;
            ST_EM_FRAG: ord_addr = path_rd_reg;
            ST_EM_OUT:  ord_addr = path_rd_reg;
            default:    ord_addr = k_m1;
        endcase
        case (cmd.state)
            ST_SORT_I:  frag_addr = ord_addr;
            default:    frag_addr = ord_rd_reg;
        endcase
    end

    assign sq      = sc_rd_reg * sc_rd_reg;
    assign cand    = cv_rd_reg + w_reg;
    assign cand_ok = (cand > cv_reg) && (se_rd_reg < fi_ss_reg) && (fe_rd_reg < fi_fs_reg);

    always_ff @(posedge clk)
    begin
        ord_rd_reg  <= ord_mem[ord_addr];
        fs_rd_reg   <= fs_mem[frag_addr];
        fe_rd_reg   <= fe_mem[frag_addr];
        ss_rd_reg   <= ss_mem[frag_addr];
        se_rd_reg   <= se_mem[frag_addr];
        sc_rd_reg   <= sc_mem[frag_addr];
        cv_rd_reg   <= cv_mem[k_a];
        pr_rd_reg   <= pr_mem[pos_reg];
        path_rd_reg <= path_mem[AW'(len_reg - emk_reg - 1'b1)];

        if (cmd.enter && count_reg < CW'(MaxFrag))
        begin
            fs_mem[count_reg[AW-1:0]] <= in_word.first_start;
            fe_mem[count_reg[AW-1:0]] <= in_word.first_end;
            ss_mem[count_reg[AW-1:0]] <= in_word.second_start;
            se_mem[count_reg[AW-1:0]] <= in_word.second_end;
            sc_mem[count_reg[AW-1:0]] <= in_word.frag_score;
        end
        case (cmd.state)
            ST_INIT_ORD: ord_mem[i_a] <= i_a;
            ST_SORT_CMP: if (fs_rd_reg > cur_fs_reg) ord_mem[k_a] <= ord_rd_reg;
            ST_SORT_PUT: ord_mem[k_a] <= cur_reg;
            ST_CH_END:
            begin
                cv_mem[i_a] <= cv_reg;
                pr_mem[i_a] <= pred_reg;
            end
            ST_TR_STEP:  path_mem[len_reg[AW-1:0]] <= pos_reg;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            i_reg        <= '0;
            k_reg        <= '0;
            cur_reg      <= '0;
            fi_fs_reg    <= '0;
            fi_ss_reg    <= '0;
            w_reg        <= '0;
            cv_reg       <= '0;
            pred_reg     <= '0;
            best_end_reg <= '0;
            best_val_reg <= '0;
            pos_reg      <= '0;
            len_reg      <= '0;
            emk_reg      <= '0;
        end
        else
        begin
            case (cmd.state)
                ST_LOAD:
                begin
                    if (cmd.enter && count_reg < CW'(MaxFrag))
                        count_reg <= count_reg + 1'b1;
                    i_reg <= '0;
                end
                ST_INIT_ORD:
                begin
                    if (count_reg == '0)
                        i_reg <= '0;
                    else if (i_reg == count_reg - 1'b1)
                        i_reg <= CW'(1);
                    else
                        i_reg <= i_reg + 1'b1;
                end
                ST_SORT_I:
                begin
                    k_reg <= i_reg;
                    cur_reg <= ord_addr;
                    // chaining starts from the first sorted position
                    if (stat.sort_i_done)
                        i_reg <= '0;
                end
                ST_SORT_CMP:
                begin
                    if (fs_rd_reg > cur_fs_reg)
                        k_reg <= k_reg - 1'b1;
                end
                ST_SORT_PUT:
                begin
                    if (i_reg + 1'b1 >= count_reg)
                        i_reg <= '0;
                    else
                        i_reg <= i_reg + 1'b1;
                end
                ST_CH_I:     k_reg <= '0;
                ST_CH_SQ:
                begin
                    w_reg    <= ValW'(sq);
                    cv_reg   <= ValW'(sq);
                    pred_reg <= {1'b1, {AW{1'b0}}};
                    fi_fs_reg <= fs_rd_reg;
                    fi_ss_reg <= ss_rd_reg;
                end
                ST_CH_CMP:
                begin
                    if (cand_ok)
                    begin
                        cv_reg   <= cand;
                        pred_reg <= {1'b0, k_a};
                    end
                    k_reg <= k_reg + 1'b1;
                end
                ST_CH_END:
                begin
                    if (i_reg == '0 || cv_reg > best_val_reg)
                    begin
                        best_end_reg <= i_a;
                        best_val_reg <= cv_reg;
                    end
                    i_reg <= i_reg + 1'b1;
                    pos_reg <= (i_reg == '0 || cv_reg > best_val_reg) ? i_a : best_end_reg;
                    len_reg <= '0;
                end
                ST_TR_STEP:
                begin
                    len_reg <= len_reg + 1'b1;
                    pos_reg <= pr_rd_reg[AW-1:0];
                    emk_reg <= '0;
                end
                ST_EM_OUT:
                begin
                    if (cmd.take)
                    begin
                        emk_reg <= emk_reg + 1'b1;
                        if (stat.em_done)
                            count_reg <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.state == ST_SORT_I)
            cur_fs_reg <= fs_mem[ord_addr];
    end

    always_comb
    begin
        stat.have_frags  = count_reg != '0;
        stat.init_done   = (i_reg == count_reg - 1'b1);
        stat.sort_i_done = (i_reg == '0) || (i_reg >= count_reg);
        stat.sort_k_zero = (k_reg == '0);
        stat.sort_move   = fs_rd_reg > cur_fs_reg;
        stat.ch_i_done   = (i_reg >= count_reg);
        stat.ch_j_done   = (k_reg >= i_reg);
        stat.tr_done     = pr_rd_reg[AW] || (len_reg + 1'b1 >= CW'(MaxFrag));
        stat.em_done     = (emk_reg + 1'b1 == len_reg);
    end

    assign out_word.fragment_index   = IdxW'(ord_rd_reg);
    assign out_word.out_first_start  = fs_rd_reg;
    assign out_word.out_first_end    = fe_rd_reg;
    assign out_word.out_second_start = ss_rd_reg;
    assign out_word.out_second_end   = se_rd_reg;
    assign out_word.out_score        = sc_rd_reg;
    assign out_word.chain_last       = stat.em_done;

endmodule
`default_nettype wire

FILE: hdl/fragment_chain_nonoverlap.sv
// top level of the fragment chaining block
`default_nettype none
// Fragments are loaded one word per cycle while the block is in its load state;
// a word with final_item set starts processing. Processing is sequential over
// the fragment memories: an ordering setup, an insertion sort by first start,
// a chaining pass that compares each fragment at sorted position i with each
// earlier sorted fragment in turn, a traceback along the best chain, and the
// emission of one word per chain entry, which waits on any output stall. No
// input is accepted while a set is being processed or emitted.
module fragment_chain_nonoverlap
    import fcn_pkg::*;
#(
    parameter int MAX_FRAGMENTS = 64
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire frag_in_t in_data,
    output logic          out_valid,
    input  wire logic     out_ready,
    output frag_out_t     out_data
);

    fcn_cmd_t  cmd;
    fcn_stat_t stat;
    logic      in_fire, out_fire;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    fcn_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .in_final  (in_data.final_item),
        .out_fire  (out_fire),
        .stat      (stat),
        .cmd       (cmd),
        .in_ready  (in_ready),
        .out_valid (out_valid)
    );

    fcn_dp #(.MaxFrag(MAX_FRAGMENTS)) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_word  (in_data),
        .stat     (stat),
        .out_word (out_data)
    );

endmodule
`default_nettype wire
